[rtl/hpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

   localparam int CAPACITY_DEF  = 256;
   localparam int KEY_WIDTH_DEF = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELMIN = 2'd1,
      OP_DELPOS = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // RAM read address select
   typedef enum logic [2:0] {
      RD_NONE,
      RD_POS,
      RD_LAST,
      RD_PARENT,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   typedef struct packed {
      logic       clear_gone;
      logic       accept_insert;
      logic       accept_delete;
      rd_sel_type rd_sel;
      logic       cap_gone;
      logic       cap_last;
      logic       cap_left;
      logic       cap_right;
      logic       move_parent;
      logic       move_child;
      logic       write_key;
      logic       respond;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic bad_pos;
      logic at_root;
      logic pos_is_last;
      logic has_child;
      logic has_right;
      logic key_lt_rdata;
      logic child_lt_key;
   } stat_type;

endpackage

[rtl/hpq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/hpq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_datapath
// Heap store, count, walk position, moving key and result registers.
// ----------------------------------------------------------------------------
module hpq_datapath
   import hpq_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF,
   parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_operation,
   input  logic signed [KEY_WIDTH-1:0] req_value,
   input  logic [CNT_W-1:0]            req_position,
   input  cmd_type                     cmd,
   output stat_type                    stat,
   output logic                        rsp_valid,
   output logic signed [KEY_WIDTH-1:0] rsp_removed_value,
   output logic signed [KEY_WIDTH-1:0] rsp_min_value,
   output logic [CNT_W-1:0]            rsp_count,
   output logic [1:0]                  rsp_status
);

   localparam int AW = $clog2(CAPACITY);

   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]            pos_ff, pos_in;
   logic [CNT_W-1:0]            child_idx_ff, child_idx_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic signed [KEY_WIDTH-1:0] child_val_ff, child_val_in;
   logic signed [KEY_WIDTH-1:0] gone_ff, gone_in;
   logic signed [KEY_WIDTH-1:0] root_ff, root_in;
   logic                        rsp_valid_ff;
   logic signed [KEY_WIDTH-1:0] rsp_removed_ff, rsp_min_ff;
   logic [CNT_W-1:0]            rsp_count_ff;
   logic [1:0]                  rsp_status_ff;

   logic [CNT_W:0]              left_pos, right_pos, parent_pos, rd_pos;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic signed [KEY_WIDTH-1:0] wr_data, rdata;

   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = {pos_ff, 1'b1};
   assign parent_pos = {2'b00, pos_ff[CNT_W-1:1]};

   // 1-based heap position to RAM address
   always_comb begin
      case (cmd.rd_sel)
         RD_POS:    rd_pos = {1'b0, pos_ff};
         RD_LAST:   rd_pos = {1'b0, cnt_ff};
         RD_PARENT: rd_pos = parent_pos;
         RD_LEFT:   rd_pos = left_pos;
         RD_RIGHT:  rd_pos = right_pos;
         default:   rd_pos = {1'b0, pos_ff};
      endcase
   end

   assign rd_addr = AW'(rd_pos - (CNT_W + 1)'(1));
   assign wr_addr = AW'(pos_ff - CNT_W'(1));
   assign wr_en   = cmd.move_parent | cmd.move_child | cmd.write_key;

   always_comb begin
      if (cmd.move_parent) begin
         wr_data = rdata;
      end else if (cmd.move_child) begin
         wr_data = child_val_ff;
      end else begin
         wr_data = key_ff;
      end
   end

   hpq_ram #(
      .WIDTH(KEY_WIDTH),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rdata)
   );

   // status toward the controller
   always_comb begin
      stat.full         = (cnt_ff == CNT_W'(CAPACITY));
      stat.empty        = (cnt_ff == '0);
      stat.bad_pos      = (req_position == '0) || (req_position > cnt_ff);
      stat.at_root      = (pos_ff == CNT_W'(1));
      stat.pos_is_last  = (pos_ff == cnt_ff);
      stat.has_child    = (left_pos <= {1'b0, cnt_ff});
      stat.has_right    = (right_pos <= {1'b0, cnt_ff});
      stat.key_lt_rdata = (key_ff < rdata);
      stat.child_lt_key = (child_val_ff < key_ff);
   end

   always_comb begin
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      child_idx_in = child_idx_ff;
      child_val_in = child_val_ff;
      gone_in      = gone_ff;
      root_in      = root_ff;

      if (cmd.clear_gone) begin
         gone_in = '0;
      end
      if (cmd.accept_insert) begin
         cnt_in = cnt_ff + CNT_W'(1);
         pos_in = cnt_ff + CNT_W'(1);
         key_in = req_value;
      end
      if (cmd.accept_delete) begin
         pos_in = (op_type'(req_operation) == OP_DELMIN) ? CNT_W'(1) : req_position;
      end
      if (cmd.cap_gone) begin
         gone_in = rdata;
      end
      if (cmd.cap_last) begin
         key_in = rdata;
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (cmd.cap_left) begin
         child_val_in = rdata;
         child_idx_in = CNT_W'(left_pos);
      end
      if (cmd.cap_right && (rdata < child_val_ff)) begin
         child_val_in = rdata;
         child_idx_in = CNT_W'(right_pos);
      end
      if (cmd.move_parent) begin
         pos_in = CNT_W'(parent_pos);
      end
      if (cmd.move_child) begin
         pos_in = child_idx_ff;
      end
      // shadow copy of the root for the min report
      if (wr_en && (wr_addr == '0)) begin
         root_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.respond;
      end
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      child_idx_ff <= child_idx_in;
      child_val_ff <= child_val_in;
      gone_ff      <= gone_in;
      root_ff      <= root_in;
      if (cmd.respond) begin
         rsp_removed_ff <= gone_ff;
         rsp_min_ff     <= (cnt_ff != '0) ? root_ff : '0;
         rsp_count_ff   <= cnt_ff;
         rsp_status_ff  <= cmd.status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_min_value     = rsp_min_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("key count above capacity");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.move_parent, cmd.move_child, cmd.write_key}))
      else $error("conflicting heap store writes");

   a_fail_no_removal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_type'(rsp_status_ff) != ST_OK)) |-> (rsp_removed_ff == '0))
      else $error("failed transaction reports a removed key");

   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_count_ff == '0)) |-> (rsp_min_ff == '0))
      else $error("empty heap reports a nonzero minimum");

endmodule

[rtl/hpq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_ctrl
// Sequencer for insert / delete with sift-up and sift-down walks.
// ----------------------------------------------------------------------------
module hpq_ctrl
   import hpq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_operation,
   input  stat_type   stat,
   output logic       busy,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHECK,
      S_UP_CMP,
      S_DEL_RD,
      S_DEL_LAST,
      S_DEL_GOT,
      S_DEL_PCMP,
      S_DN_CHECK,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_CMP,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       busy_ff, busy_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.rd_sel = RD_NONE;
      cmd.status = status_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.clear_gone = 1'b1;
               status_in      = ST_OK;
               state_in       = S_DONE;
               case (op_type'(req_operation))
                  OP_INSERT: begin
                     if (stat.full) begin
                        status_in = ST_FULL;
                     end else begin
                        cmd.accept_insert = 1'b1;
                        state_in          = S_UP_CHECK;
                     end
                  end
                  OP_DELMIN: begin
                     if (stat.empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cmd.accept_delete = 1'b1;
                        state_in          = S_DEL_RD;
                     end
                  end
                  OP_DELPOS: begin
                     if (stat.empty) begin
                        status_in = ST_EMPTY;
                     end else if (stat.bad_pos) begin
                        status_in = ST_BADPOS;
                     end else begin
                        cmd.accept_delete = 1'b1;
                        state_in          = S_DEL_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_UP_CHECK: begin
            if (stat.at_root) begin
               cmd.write_key = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.key_lt_rdata) begin
               cmd.move_parent = 1'b1;
               state_in        = S_UP_CHECK;
            end else begin
               cmd.write_key = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DEL_RD: begin
            cmd.rd_sel = RD_POS;
            state_in   = S_DEL_LAST;
         end
         S_DEL_LAST: begin
            cmd.rd_sel   = RD_LAST;
            cmd.cap_gone = 1'b1;
            state_in     = S_DEL_GOT;
         end
         S_DEL_GOT: begin
            cmd.cap_last = 1'b1;
            // removing the last key needs no refill
            if (stat.pos_is_last) begin
               state_in = S_DONE;
            end else if (stat.at_root) begin
               state_in = S_DN_CHECK;
            end else begin
               cmd.rd_sel = RD_PARENT;
               state_in   = S_DEL_PCMP;
            end
         end
         S_DEL_PCMP: begin
            if (stat.key_lt_rdata) begin
               cmd.move_parent = 1'b1;
               state_in        = S_UP_CHECK;
            end else begin
               state_in = S_DN_CHECK;
            end
         end
         S_DN_CHECK: begin
            if (!stat.has_child) begin
               cmd.write_key = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_LEFT;
            end
         end
         S_DN_LEFT: begin
            cmd.cap_left = 1'b1;
            if (stat.has_right) begin
               cmd.rd_sel = RD_RIGHT;
               state_in   = S_DN_RIGHT;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_RIGHT: begin
            cmd.cap_right = 1'b1;
            state_in      = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.child_lt_key) begin
               cmd.move_child = 1'b1;
               state_in       = S_DN_CHECK;
            end else begin
               cmd.write_key = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
         busy_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         busy_ff   <= busy_in;
      end
   end

   assign busy = busy_ff;

   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != S_IDLE))
      else $error("busy out of step with sequencer");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted transaction did not raise busy");

endmodule

[rtl/binary_min_heap_priority_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_top
// Binary min-heap priority queue: insert, delete-min, delete-at-position.
// ----------------------------------------------------------------------------
// One transaction at a time: a request is taken when start is high and busy
// is low, and its result appears on the rsp_ ports for one cycle with
// rsp_valid high; it must be captured then, since rsp_valid is not held.
// The time from the accepting edge to the cycle that carries rsp_valid is set
// by the heap walk through the single-read-port store: failed requests and
// operation 3 go straight to the response; insert reads and compares the parent
// at each level it climbs and writes the key where it stops; delete reads the
// removed key and the last key and ends there if the last key went, else it
// climbs like insert or walks down, reading the children of each node and
// moving the smaller child up, and writes the key where it stops.
// busy drops in the cycle that rsp_valid rises.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_top
   import hpq_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF,
   parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic signed [KEY_WIDTH-1:0] req_value,
   input  logic [CNT_W-1:0]            req_position,
   output logic                        rsp_valid,
   output logic signed [KEY_WIDTH-1:0] rsp_removed_value,
   output logic signed [KEY_WIDTH-1:0] rsp_min_value,
   output logic [CNT_W-1:0]            rsp_count,
   output logic [1:0]                  rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   hpq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_operation(req_operation),
      .stat         (stat),
      .busy         (busy),
      .cmd          (cmd)
   );

   hpq_datapath #(
      .CAPACITY (CAPACITY),
      .KEY_WIDTH(KEY_WIDTH),
      .CNT_W    (CNT_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .req_position     (req_position),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_removed_value(rsp_removed_value),
      .rsp_min_value    (rsp_min_value),
      .rsp_count        (rsp_count),
      .rsp_status       (rsp_status)
   );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the binary min-heap priority queue against a heap tracked in the
// bench: directed corner cases first, then randomized fill, mix and drain.
// ----------------------------------------------------------------------------
module testbench;
   import hpq_pkg::*;

   localparam int CAP = CAPACITY_DEF;
   localparam int KW  = KEY_WIDTH_DEF;
   localparam int CW  = $clog2(CAP + 1);

   localparam int RANDOM_OPS = 1620;
   localparam int PHASE_LEN  = 405;

   typedef struct packed {
      logic signed [KW-1:0] removed;
      logic signed [KW-1:0] min_key;
      logic [CW-1:0]        count;
      status_type           status;
   } heap_outcome_type;

   // Heap kept alongside the DUT plus the queue of outcomes still owed
   class heap_tracker;
      logic signed [KW-1:0] heap_keys [1:CAP];
      int                   key_total;
      heap_outcome_type     owed_outcomes [$];
      int                   mismatches;
      int                   errors;

      function new();
         key_total  = 0;
         mismatches = 0;
         errors     = 0;
      endfunction

      function void sift_up(int pos, logic signed [KW-1:0] key);
         while (pos > 1 && key < heap_keys[pos / 2]) begin
            heap_keys[pos] = heap_keys[pos / 2];
            pos = pos / 2;
         end
         heap_keys[pos] = key;
      endfunction

      function void sift_down(int pos, logic signed [KW-1:0] key);
         int child;
         bit done;
         done = 0;
         while (!done) begin
            child = 2 * pos;
            if (child > key_total) begin
               done = 1;
            end else begin
               if (child + 1 <= key_total && heap_keys[child + 1] < heap_keys[child])
                  child++;
               if (heap_keys[child] < key) begin
                  heap_keys[pos] = heap_keys[child];
                  pos = child;
               end else begin
                  done = 1;
               end
            end
         end
         heap_keys[pos] = key;
      endfunction

      function logic signed [KW-1:0] remove_at(int pos);
         logic signed [KW-1:0] gone;
         logic signed [KW-1:0] last;
         gone = heap_keys[pos];
         last = heap_keys[key_total];
         key_total--;
         // hole refilled by the last key, which may need to climb instead
         if (pos <= key_total) begin
            if (pos > 1 && last < heap_keys[pos / 2])
               sift_up(pos, last);
            else
               sift_down(pos, last);
         end
         return gone;
      endfunction

      // Apply one accepted transaction and queue the outcome it must produce
      function void note_request(op_type op, logic signed [KW-1:0] value,
                                 logic [CW-1:0] position);
         heap_outcome_type o;
         o.removed = '0;
         o.status  = ST_OK;
         case (op)
            OP_INSERT: begin
               if (key_total >= CAP) begin
                  o.status = ST_FULL;
               end else begin
                  key_total++;
                  sift_up(key_total, value);
               end
            end
            OP_DELMIN: begin
               if (key_total == 0)
                  o.status = ST_EMPTY;
               else
                  o.removed = remove_at(1);
            end
            OP_DELPOS: begin
               if (key_total == 0)
                  o.status = ST_EMPTY;
               else if (position == 0 || position > key_total)
                  o.status = ST_BADPOS;
               else
                  o.removed = remove_at(int'(position));
            end
            default: ;
         endcase
         o.min_key = (key_total > 0) ? heap_keys[1] : '0;
         o.count   = CW'(key_total);
         owed_outcomes.push_back(o);
      endfunction

      function void check_response(heap_outcome_type got);
         heap_outcome_type want;
         if (owed_outcomes.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected response removed=%0d min=%0d count=%0d status=%0d",
                        $time, got.removed, got.min_key, got.count, got.status);
            mismatches++;
            errors++;
         end else begin
            want = owed_outcomes.pop_front();
            if (got.removed !== want.removed || got.min_key !== want.min_key ||
                got.count !== want.count || got.status !== want.status) begin
               if (mismatches < 10) begin
                  $display("%0t: mismatch", $time);
                  $display("   expected removed=%0d min=%0d count=%0d status=%0d",
                           want.removed, want.min_key, want.count, want.status);
                  $display("   actual   removed=%0d min=%0d count=%0d status=%0d",
                           got.removed, got.min_key, got.count, got.status);
               end
               mismatches++;
               errors++;
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [1:0]           req_operation = '0;
   logic signed [KW-1:0] req_value = '0;
   logic [CW-1:0]        req_position = '0;
   logic                 rsp_valid;
   logic signed [KW-1:0] rsp_removed_value;
   logic signed [KW-1:0] rsp_min_value;
   logic [CW-1:0]        rsp_count;
   logic [1:0]           rsp_status;

   heap_tracker tracker;

   binary_min_heap_priority_queue_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_removed_value (rsp_removed_value),
      .rsp_min_value     (rsp_min_value),
      .rsp_count         (rsp_count),
      .rsp_status        (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      heap_outcome_type got;
      if (!reset && rsp_valid) begin
         got.removed = rsp_removed_value;
         got.min_key = rsp_min_value;
         got.count   = rsp_count;
         got.status  = status_type'(rsp_status);
         tracker.check_response(got);
      end
   end

   // start is left high after acceptance so back-to-back transactions need
   // only one assignment per edge
   task automatic send_request(op_type op, logic signed [KW-1:0] value,
                               logic [CW-1:0] position);
      int gap;
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0)
         gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= value;
      req_position  <= position;
      do
         @(posedge clock);
      while (busy);
      tracker.note_request(op, value, position);
   endtask

   function automatic logic signed [KW-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return KW'($urandom);
      else if (r < 70)
         return KW'($urandom_range(0, 8)) - KW'(4);
      else if (r < 85)
         case ($urandom_range(0, 4))
            0:       return {1'b1, {(KW-1){1'b0}}};
            1:       return {1'b1, {(KW-2){1'b0}}, 1'b1};
            2:       return {1'b0, {(KW-1){1'b1}}};
            3:       return '1;
            default: return '0;
         endcase
      else
         return KW'($urandom_range(0, 200)) - KW'(100);
   endfunction

   function automatic logic [CW-1:0] pick_position();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = tracker.key_total;
      if (r < 80 && n > 0)
         return CW'($urandom_range(1, n));
      else if (r < 85)
         return CW'(n);
      else if (r < 90)
         return '0;
      else if (r < 95)
         return CW'(n + 1);
      else
         return CW'($urandom_range(0, (1 << CW) - 1));
   endfunction

   function automatic op_type pick_op(int phase);
      int r;
      int ins_lim;
      int min_lim;
      r = $urandom_range(0, 99);
      case (phase % 4)
         0:       begin ins_lim = 80; min_lim = 88; end  // fill
         2:       begin ins_lim = 15; min_lim = 55; end  // drain
         default: begin ins_lim = 45; min_lim = 70; end  // mixed
      endcase
      if (r < ins_lim)
         return OP_INSERT;
      else if (r < min_lim)
         return OP_DELMIN;
      else if (r < 97)
         return OP_DELPOS;
      else
         return OP_NOP;
   endfunction

   initial begin
      op_type op;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty heap
      send_request(OP_DELMIN, '0, '0);
      send_request(OP_DELPOS, '0, '0);
      send_request(OP_DELPOS, 16'sd1, 9'd300);
      send_request(OP_NOP, '0, '0);
      // build 1,100,2,101,102,3,4
      send_request(OP_INSERT, 16'sd1, '0);
      send_request(OP_INSERT, 16'sd100, '0);
      send_request(OP_INSERT, 16'sd2, '0);
      send_request(OP_INSERT, 16'sd101, '0);
      send_request(OP_INSERT, 16'sd102, '0);
      send_request(OP_INSERT, 16'sd3, '0);
      send_request(OP_INSERT, 16'sd4, '0);
      // bad positions
      send_request(OP_DELPOS, '0, 9'd0);
      send_request(OP_DELPOS, '0, 9'd8);
      send_request(OP_DELPOS, 16'sd0, 9'd511);
      // moved key climbs above its new parent
      send_request(OP_DELPOS, '0, 9'd4);
      // last position, no sift
      send_request(OP_DELPOS, '0, 9'd6);
      send_request(OP_DELMIN, '0, '0);
      send_request(OP_INSERT, 16'sh8000, '0);
      send_request(OP_INSERT, 16'sd32767, '0);
      send_request(OP_INSERT, 16'sd32767, '0);
      send_request(OP_INSERT, -16'sd1, '0);
      send_request(OP_NOP, 16'sd7, 9'd3);
      send_request(OP_DELPOS, '0, 9'd1);

      for (int i = 0; i < RANDOM_OPS; i++) begin
         op = pick_op(i / PHASE_LEN);
         send_request(op, pick_key(), pick_position());
      end
      start <= 1'b0;

      while (tracker.owed_outcomes.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);

      if (tracker.errors == 0 && tracker.owed_outcomes.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/hpq_pkg.sv
rtl/hpq_ram.sv
rtl/hpq_datapath.sv
rtl/hpq_ctrl.sv
rtl/binary_min_heap_priority_queue_top.sv
tb/testbench.sv
